// ----- rtl/sbda_pkg.sv -----
// Shared types and constants for the signed binary to decimal ASCII converter.
// No dependencies; imported by sbda_dabble and the top level.
package sbda_pkg;

	typedef logic [3:0] bcd_digit_t;

	localparam int DEF_VALUE_BITS = 32;

	localparam bcd_digit_t DIGIT_ZERO = 4'd0;
	localparam bcd_digit_t DIGIT_NINE = 4'd9;
	localparam bcd_digit_t DIGIT_FIVE = 4'd5;
	localparam bcd_digit_t DIGIT_ADJ  = 4'd3;

	localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
	localparam logic [7:0] CHAR_MINUS     = 8'd45;

endpackage

// ----- rtl/sbda_dabble.sv -----
// Shift-and-adjust step of the binary to BCD conversion (double dabble).
// Depends on sbda_pkg for the BCD digit type and constants.
module sbda_dabble
	import sbda_pkg::*;
#(
	parameter int NDIG = 10
) (
	input  bcd_digit_t [NDIG-1:0] bcd_in,
	input  logic                  bit_in,
	output bcd_digit_t [NDIG-1:0] bcd_out
);

	bcd_digit_t [NDIG-1:0] adj;

	// Every digit of five or more gets three added so that the shift carries
	// it correctly into the next decimal place.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_in[i] >= DIGIT_FIVE) begin
				adj[i] = bcd_in[i] + DIGIT_ADJ;
			end else begin
				adj[i] = bcd_in[i];
			end
		end
	end

	// Shift the adjusted digits up by one bit and bring in the next input bit.
	// The bit shifted out of the top digit is always zero for a magnitude that
	// fits in NDIG digits.
	assign bcd_out = {adj[NDIG-1][2:0], adj[NDIG-2:0], bit_in};

endmodule

// ----- rtl/signed_binary_to_decimal_ascii.sv -----
// Signed binary to decimal ASCII converter, top level.
// Depends on sbda_pkg and sbda_dabble.
//
// Usage: one signed two's-complement value is taken on the input channel
// (in_valid / in_stall, payload value). The block emits its decimal text on
// the output channel (out_valid / out_stall, payload text_char, last_char),
// one ASCII character per item, most significant first: a minus sign for
// negative values, then the digits without leading zeros. Zero gives "0".
// last_char marks the final character of each number.
//
// Timing: in_stall is high from the cycle after an accept until the last
// character has been handed to the output register. The magnitude is turned
// into BCD by one shared shift-and-adjust step per input bit, then leading
// zero digits are dropped one at a time until the first digit to keep is
// found, and the characters follow. NDIG is the BCD digit count (10 at 32).
// The output register holds its character while out_stall is high, and the
// sequencer waits for it; the next value may be accepted while the final
// character still waits. Reset clears the sequencer and the output valid.
module signed_binary_to_decimal_ascii
	import sbda_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   text_char,
	output logic                         last_char
);

	// Enough decimal digits for a magnitude of up to 2^(VALUE_BITS-1).
	localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BW   = $clog2(VALUE_BITS + 1);
	localparam int DW   = $clog2(NDIG + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SKIP = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]            state_q;
	logic [VALUE_BITS-1:0] mag_q;
	bcd_digit_t [NDIG-1:0] bcd_q;
	bcd_digit_t [NDIG-1:0] bcd_next;
	logic                  neg_q;
	logic [BW-1:0]         bit_cnt_q;
	logic [DW-1:0]         dig_cnt_q;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;

	logic                  in_accept;
	logic                  out_free;
	logic                  skip_more;
	logic                  last_dig;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	// The output register can take a new character when empty or being read.
	assign out_free  = !out_valid_q || !out_stall;
	assign skip_more = (bcd_q[NDIG-1] == DIGIT_ZERO) && (dig_cnt_q != DW'(1));
	assign last_dig  = (dig_cnt_q == DW'(1));

	sbda_dabble #(
		.NDIG(NDIG)
	) u_dabble (
		.bcd_in (bcd_q),
		.bit_in (mag_q[VALUE_BITS-1]),
		.bcd_out(bcd_next)
	);

	// Sequencer and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (bit_cnt_q == BW'(1)) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (!skip_more) begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free && last_dig) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					// Negating the most negative value yields its exact unsigned
					// magnitude in VALUE_BITS bits.
					mag_q     <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
					neg_q     <= value[VALUE_BITS-1];
					bcd_q     <= '0;
					bit_cnt_q <= BW'(VALUE_BITS);
				end
			end
			ST_CONV: begin
				bcd_q     <= bcd_next;
				mag_q     <= mag_q << 1;
				bit_cnt_q <= bit_cnt_q - BW'(1);
				dig_cnt_q <= DW'(NDIG);
			end
			ST_SKIP: begin
				if (skip_more) begin
					bcd_q     <= {bcd_q[NDIG-2:0], DIGIT_ZERO};
					dig_cnt_q <= dig_cnt_q - DW'(1);
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					bcd_q     <= {bcd_q[NDIG-2:0], DIGIT_ZERO};
					dig_cnt_q <= dig_cnt_q - DW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == ST_SIGN) || (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_SIGN) begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
			end else if (state_q == ST_EMIT) begin
				char_q <= {ASCII_DIGIT_HI, bcd_q[NDIG-1]};
				last_q <= last_dig;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign text_char = char_q;
	assign last_char = last_q;

`ifndef SYNTHESIS
	// Emission always has at least one digit left to send.
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (dig_cnt_q != '0))
		else $error("emit state with no digits left");

	// Leading-zero removal stops at a nonzero digit or at the last digit.
	a_skip_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP && !skip_more) |=>
		(bcd_q[NDIG-1] != DIGIT_ZERO || dig_cnt_q == DW'(1)))
		else $error("leading zero left in front of the number");

	// The conversion only ever leaves valid decimal digits.
	a_bcd_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (bcd_q[NDIG-1] <= DIGIT_NINE))
		else $error("digit out of decimal range");
`endif

endmodule
